// ===== design/dlq_pkg.sv =====
`timescale 1ns / 1ps

package dlq_pkg;

   localparam int ID_BITS        = 4;
   localparam int REQ_DELAY_BITS = 16;
   localparam int MAX_RINGS      = 16;
   localparam int RING_BITS      = 5;

   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_SCHEDULE = 2'd1;
   localparam logic [1:0] FUNC_CANCEL   = 2'd2;

   localparam logic [1:0] KIND_DONE   = 2'd0;
   localparam logic [1:0] KIND_RANG   = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   typedef struct packed {
      logic [1:0]                func;
      logic [ID_BITS-1:0]        alarm_id;
      logic [REQ_DELAY_BITS-1:0] delay;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [ID_BITS-1:0] rung_id;
      logic               last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIND,
      ST_WALK,
      ST_TICK,
      ST_TDEC
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_DEC
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        add_next;
   } cell_ctrl_type;

endpackage

// ===== design/dlq_cell.sv =====
`timescale 1ns / 1ps

module dlq_cell import dlq_pkg::*; #(
   parameter int INDEX      = 0,
   parameter int DELAY_BITS = 16,
   parameter int IDX_W      = 4
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [IDX_W-1:0]      pos,
   input  logic [ID_BITS-1:0]    new_alarm,
   input  logic [DELAY_BITS-1:0] new_delta,
   input  logic [ID_BITS-1:0]    left_alarm,
   input  logic [DELAY_BITS-1:0] left_delta,
   input  logic [ID_BITS-1:0]    right_alarm,
   input  logic [DELAY_BITS-1:0] right_delta,
   output logic [ID_BITS-1:0]    alarm,
   output logic [DELAY_BITS-1:0] delta
);

   localparam int CW = IDX_W + 1;
   localparam logic [CW-1:0] MY_IDX = CW'(INDEX);

   logic [ID_BITS-1:0]    alarm_ff, alarm_in;
   logic [DELAY_BITS-1:0] delta_ff, delta_in;
   logic [CW-1:0]         pos_w;
   logic                  at_pos, after_pos, next_pos;

   assign pos_w     = {1'b0, pos};
   assign at_pos    = (MY_IDX == pos_w);
   assign after_pos = (MY_IDX > pos_w);
   assign next_pos  = (MY_IDX == pos_w + CW'(1));

   always_comb begin
      alarm_in = alarm_ff;
      delta_in = delta_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (at_pos) begin
               alarm_in = new_alarm;
               delta_in = new_delta;
            end else if (next_pos) begin
               // The old entry at the insertion point now counts from the new alarm.
               alarm_in = left_alarm;
               delta_in = left_delta - new_delta;
            end else if (after_pos) begin
               alarm_in = left_alarm;
               delta_in = left_delta;
            end
         end
         CELL_REMOVE: begin
            if (at_pos) begin
               alarm_in = right_alarm;
               delta_in = ctrl.add_next ? right_delta + delta_ff : right_delta;
            end else if (after_pos) begin
               alarm_in = right_alarm;
               delta_in = right_delta;
            end
         end
         CELL_DEC: begin
            if (at_pos) begin
               delta_in = delta_ff - DELAY_BITS'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      alarm_ff <= alarm_in;
      delta_ff <= delta_in;
   end

   assign alarm = alarm_ff;
   assign delta = delta_ff;

endmodule

// ===== design/delta_list_timer_queue.sv =====
`timescale 1ns / 1ps

// A schedule searches the ids over count + 1 slots, then walks over up to count + 1 slots;
// a cancel searches up to the id's position (over all slots when the id is absent); a tick
// runs in ST_TICK; a full queue or an unknown function is rejected directly from idle.
// A tick that rings gives one beat a cycle, then passes through ST_TDEC before it goes idle.
// One item at a time; results are single-cycle strobes that the receiver cannot stall.
// Synchronous active-high reset empties the queue; slot contents are not cleared.
module delta_list_timer_queue import dlq_pkg::*; #(
   parameter int NUM_ALARMS = 16,
   parameter int DELAY_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int IDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;
   localparam int CNT_W = $clog2(NUM_ALARMS + 1);

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        pos_ff, pos_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [RING_BITS-1:0]    n_ff, n_in;
   logic [1:0]              func_ff, func_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [DELAY_BITS-1:0]   d_ff, d_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   cell_ctrl_type           ctrl;
   logic [IDX_W-1:0]        cell_pos;
   logic [ID_BITS-1:0]      cell_alarm [NUM_ALARMS];
   logic [DELAY_BITS-1:0]   cell_delta [NUM_ALARMS];
   logic [ID_BITS-1:0]      sel_alarm;
   logic [DELAY_BITS-1:0]   sel_delta;
   logic [DELAY_BITS-1:0]   head1_delta;
   logic                    ring, more;

   genvar g;
   generate
      for (g = 0; g < NUM_ALARMS; g++) begin : g_cell
         logic [ID_BITS-1:0]    l_alarm, r_alarm;
         logic [DELAY_BITS-1:0] l_delta, r_delta;
         if (g == 0) begin : g_first
            assign l_alarm = '0;
            assign l_delta = '0;
         end else begin : g_mid_l
            assign l_alarm = cell_alarm[g-1];
            assign l_delta = cell_delta[g-1];
         end
         if (g == NUM_ALARMS - 1) begin : g_last
            assign r_alarm = '0;
            assign r_delta = '0;
         end else begin : g_mid_r
            assign r_alarm = cell_alarm[g+1];
            assign r_delta = cell_delta[g+1];
         end
         dlq_cell #(
            .INDEX      (g),
            .DELAY_BITS (DELAY_BITS),
            .IDX_W      (IDX_W)
         ) u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .pos         (cell_pos),
            .new_alarm   (id_ff),
            .new_delta   (d_ff),
            .left_alarm  (l_alarm),
            .left_delta  (l_delta),
            .right_alarm (r_alarm),
            .right_delta (r_delta),
            .alarm       (cell_alarm[g]),
            .delta       (cell_delta[g])
         );
      end
      if (NUM_ALARMS > 1) begin : g_head1
         assign head1_delta = cell_delta[1];
      end else begin : g_no_head1
         assign head1_delta = '0;
      end
   endgenerate

   assign sel_alarm = cell_alarm[pos_ff[IDX_W-1:0]];
   assign sel_delta = cell_delta[pos_ff[IDX_W-1:0]];

   // A ring is the final one unless the slot behind the head is also due and MAX_RINGS is not yet reached.
   assign ring = (cnt_ff != '0) && (cell_delta[0] == '0) && (n_ff < RING_BITS'(MAX_RINGS));
   assign more = (cnt_ff > CNT_W'(1)) && (head1_delta == '0)
                 && ((n_ff + RING_BITS'(1)) < RING_BITS'(MAX_RINGS));

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      func_in      = func_ff;
      id_in        = id_ff;
      d_in         = d_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ctrl.op      = CELL_HOLD;
      ctrl.add_next = 1'b0;
      cell_pos     = pos_ff[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in = req_data.func;
               id_in   = req_data.alarm_id;
               d_in    = DELAY_BITS'(req_data.delay);
               pos_in  = '0;
               n_in    = '0;
               case (req_data.func)
                  FUNC_TICK: begin
                     state_in = ST_TICK;
                  end
                  FUNC_SCHEDULE: begin
                     if (cnt_ff >= CNT_W'(NUM_ALARMS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_in = '{kind: KIND_REJECT, rung_id: req_data.alarm_id, last: 1'b1};
                     end else begin
                        state_in = ST_FIND;
                     end
                  end
                  FUNC_CANCEL: begin
                     state_in = ST_FIND;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_in = '{kind: KIND_REJECT, rung_id: req_data.alarm_id, last: 1'b1};
                  end
               endcase
            end
         end
         ST_FIND: begin
            if (pos_ff == cnt_ff) begin
               if (func_ff == FUNC_SCHEDULE) begin
                  pos_in   = '0;
                  state_in = ST_WALK;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = '{kind: KIND_REJECT, rung_id: id_ff, last: 1'b1};
                  state_in = ST_IDLE;
               end
            end else if (sel_alarm == id_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               if (func_ff == FUNC_SCHEDULE) begin
                  rsp_in = '{kind: KIND_REJECT, rung_id: id_ff, last: 1'b1};
               end else begin
                  ctrl.op       = CELL_REMOVE;
                  ctrl.add_next = 1'b1;
                  cnt_in        = cnt_ff - CNT_W'(1);
                  rsp_in = '{kind: KIND_DONE, rung_id: id_ff, last: 1'b1};
               end
            end else begin
               pos_in = pos_ff + CNT_W'(1);
            end
         end
         ST_WALK: begin
            if ((pos_ff < cnt_ff) && (d_ff > sel_delta)) begin
               d_in   = d_ff - sel_delta;
               pos_in = pos_ff + CNT_W'(1);
            end else begin
               ctrl.op      = CELL_INSERT;
               cnt_in       = cnt_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: KIND_DONE, rung_id: id_ff, last: 1'b1};
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            cell_pos = '0;
            if (ring) begin
               ctrl.op      = CELL_REMOVE;
               cnt_in       = cnt_ff - CNT_W'(1);
               n_in         = n_ff + RING_BITS'(1);
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: KIND_RANG, rung_id: cell_alarm[0], last: !more};
               if (!more) begin
                  state_in = ST_TDEC;
               end
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in = '{kind: KIND_DONE, rung_id: '0, last: 1'b1};
               if ((cnt_ff != '0) && (cell_delta[0] != '0)) begin
                  ctrl.op = CELL_DEC;
               end
               state_in = ST_IDLE;
            end
         end
         ST_TDEC: begin
            cell_pos = '0;
            if ((cnt_ff != '0) && (cell_delta[0] != '0)) begin
               ctrl.op = CELL_DEC;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      n_ff    <= n_in;
      func_ff <= func_in;
      id_ff   <= id_in;
      d_ff    <= d_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/tb_delta_list_timer_queue.sv =====
`timescale 1ns / 1ps

module tb_delta_list_timer_queue;
   import dlq_pkg::*;

   localparam int NUM_ALARMS = 16;
   localparam int DELAY_BITS = 16;
   localparam logic [1:0] FUNC_UNDEFINED = 2'd3;
   localparam int QUIET_LIMIT = 5000;
   localparam int RANDOM_PER_PHASE = 145;
   localparam int SETTLE_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req = '0;
   logic    rsp_valid;
   rsp_type rsp;

   // Shadow copy of the alarm list, kept in step with every accepted request beat.
   logic [ID_BITS-1:0]    shadow_alarm [NUM_ALARMS];
   logic [DELAY_BITS-1:0] shadow_delta [NUM_ALARMS];
   int                    shadow_count = 0;

   req_type pending_beats [$];
   rsp_type alarm_outcomes [$];
   int      sender_idle_pct = 29;
   int      idle_plan [3] = '{29, 80, 0};
   logic    beat_taken = 1'b0;
   int      mismatches = 0;
   int      quiet_cycles = 0;

   delta_list_timer_queue #(
      .NUM_ALARMS(NUM_ALARMS),
      .DELAY_BITS(DELAY_BITS)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_data (req),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int find_slot(logic [ID_BITS-1:0] id);
      for (int i = 0; i < shadow_count; i++)
         if (shadow_alarm[i] == id) return i;
      return -1;
   endfunction

   function automatic void drop_slot(int pos);
      for (int i = pos; i + 1 < shadow_count; i++) begin
         shadow_alarm[i] = shadow_alarm[i + 1];
         shadow_delta[i] = shadow_delta[i + 1];
      end
      shadow_count--;
   endfunction

   function automatic void advance_alarm_queue(req_type beat);
      int                    pos;
      int                    rings;
      logic [DELAY_BITS-1:0] left;
      rsp_type               outcome;
      outcome = '{kind: KIND_REJECT, rung_id: beat.alarm_id, last: 1'b1};
      case (beat.func)
         FUNC_TICK: begin
            // The leading zero deltas are exactly the alarms that ring on this tick.
            rings = 0;
            while (rings < shadow_count && rings < MAX_RINGS && shadow_delta[rings] == '0)
               rings++;
            for (int i = 0; i < rings; i++)
               alarm_outcomes.push_back('{kind: KIND_RANG, rung_id: shadow_alarm[i],
                                          last: (i == rings - 1)});
            for (int i = 0; i < rings; i++)
               drop_slot(0);
            if (shadow_count > 0 && shadow_delta[0] != '0)
               shadow_delta[0] = shadow_delta[0] - DELAY_BITS'(1);
            if (rings == 0)
               alarm_outcomes.push_back('{kind: KIND_DONE, rung_id: '0, last: 1'b1});
         end
         FUNC_SCHEDULE: begin
            if (shadow_count < NUM_ALARMS && find_slot(beat.alarm_id) < 0) begin
               left = beat.delay;
               pos = 0;
               while (pos < shadow_count && left > shadow_delta[pos]) begin
                  left = left - shadow_delta[pos];
                  pos++;
               end
               for (int i = shadow_count; i > pos; i--) begin
                  shadow_alarm[i] = shadow_alarm[i - 1];
                  shadow_delta[i] = shadow_delta[i - 1];
               end
               shadow_alarm[pos] = beat.alarm_id;
               shadow_delta[pos] = left;
               shadow_count++;
               if (pos + 1 < shadow_count)
                  shadow_delta[pos + 1] = shadow_delta[pos + 1] - left;
               outcome.kind = KIND_DONE;
            end
            alarm_outcomes.push_back(outcome);
         end
         FUNC_CANCEL: begin
            pos = find_slot(beat.alarm_id);
            if (pos >= 0) begin
               if (pos + 1 < shadow_count)
                  shadow_delta[pos + 1] = shadow_delta[pos + 1] + shadow_delta[pos];
               drop_slot(pos);
               outcome.kind = KIND_DONE;
            end
            alarm_outcomes.push_back(outcome);
         end
         default: begin
            alarm_outcomes.push_back(outcome);
         end
      endcase
   endfunction

   function automatic void note_mismatch(string detail);
      if (mismatches < REPORT_LIMIT)
         $display("Mismatch at %0t: %s", $time, detail);
      mismatches++;
   endfunction

   function automatic void queue_beat(logic [1:0] func, logic [ID_BITS-1:0] id,
                                      logic [REQ_DELAY_BITS-1:0] delay);
      pending_beats.push_back('{func: func, alarm_id: id, delay: delay});
   endfunction

   // Mostly short delays so that alarms actually come due, with the odd wide one.
   function automatic req_type random_beat();
      req_type beat;
      int      pick;
      int      span;
      pick = $urandom_range(0, 99);
      span = $urandom_range(0, 99);
      beat.alarm_id = ID_BITS'($urandom_range(0, 15));
      if (span < 60)
         beat.delay = REQ_DELAY_BITS'($urandom_range(0, 8));
      else if (span < 85)
         beat.delay = REQ_DELAY_BITS'($urandom_range(0, 100));
      else
         beat.delay = REQ_DELAY_BITS'($urandom_range(0, 65535));
      if (pick < 45)
         beat.func = FUNC_SCHEDULE;
      else if (pick < 70)
         beat.func = FUNC_CANCEL;
      else if (pick < 97)
         beat.func = FUNC_TICK;
      else
         beat.func = FUNC_UNDEFINED;
      return beat;
   endfunction

   // A request stays on the port until it is taken; a new one is only offered after that.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || beat_taken) begin
         if (pending_beats.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req   <= pending_beats.pop_front();
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         beat_taken <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         if (start && !busy)
            advance_alarm_queue(req);
         if (rsp_valid) begin
            if (alarm_outcomes.size() == 0) begin
               note_mismatch($sformatf("unexpected result kind=%0d id=%0d last=%0d",
                                       rsp.kind, rsp.rung_id, rsp.last));
            end else begin
               due = alarm_outcomes.pop_front();
               if (rsp.kind !== due.kind || rsp.rung_id !== due.rung_id ||
                   rsp.last !== due.last)
                  note_mismatch($sformatf(
                     "expected kind=%0d id=%0d last=%0d, got kind=%0d id=%0d last=%0d",
                     due.kind, due.rung_id, due.last, rsp.kind, rsp.rung_id, rsp.last));
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_beat(FUNC_TICK, 4'd9, 16'hFFFF);
      queue_beat(FUNC_UNDEFINED, 4'd15, 16'hFFFF);
      queue_beat(FUNC_CANCEL, 4'd5, 16'h0000);
      // A lone alarm at the widest delay, then cancelled with no successor.
      queue_beat(FUNC_SCHEDULE, 4'd15, 16'hFFFF);
      queue_beat(FUNC_CANCEL, 4'd15, 16'h0000);
      // Fill the list with alarms all due at once; the tick must ring every one.
      for (int i = 0; i < NUM_ALARMS; i++)
         queue_beat(FUNC_SCHEDULE, i[ID_BITS-1:0], 16'h0000);
      queue_beat(FUNC_SCHEDULE, 4'd3, 16'h0001);
      queue_beat(FUNC_TICK, 4'd0, 16'h0000);
      // An equal delay goes in front; cancelling it hands its delta to the successor.
      queue_beat(FUNC_SCHEDULE, 4'd1, 16'h0005);
      queue_beat(FUNC_SCHEDULE, 4'd2, 16'h0005);
      queue_beat(FUNC_CANCEL, 4'd2, 16'h0000);

      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = idle_plan[p];
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            pending_beats.push_back(random_beat());
         while (pending_beats.size() > 0)
            @(posedge clock);
      end

      while (start || alarm_outcomes.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
